// ===== sv/phrd_pkg.sv =====
package phrd_pkg;
	localparam int SMOOTH_TAPS_DEF    = 4;
	localparam int BASELINE_DEPTH_DEF = 64;
	localparam int HISTORY_DEPTH_DEF  = 8;

	localparam int SAMPLE_W = 18;
	localparam int AC_W     = 19;
	localparam int TIME_W   = 32;
	localparam int GAP_W    = 16;
	localparam int BPM_W    = 16;
	localparam int CFG_W    = 19;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP   = 1'd1;

	localparam logic [23:0] BPM_NUMERATOR = 24'd15360000;
	localparam logic [BPM_W-1:0] BPM_LOW  = 16'd10240;
	localparam logic [BPM_W-1:0] BPM_HIGH = 16'd51200;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SMOOTH,
		ST_BASE_RD,
		ST_BASE_WR,
		ST_PEAK,
		ST_DIV,
		ST_HIST,
		ST_MEAN,
		ST_AVG,
		ST_OUT
	} phrd_state_t;
endpackage

// ===== sv/phrd_if.sv =====
interface phrd_in_if;
	import phrd_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] ir_sample;
	logic [TIME_W-1:0]   time_ms;
	modport source (output valid, ir_sample, time_ms, input ready);
	modport sink   (input valid, ir_sample, time_ms, output ready);
endinterface

interface phrd_out_if;
	import phrd_pkg::*;
	logic                valid;
	logic                ready;
	logic [BPM_W-1:0]    current_bpm_q8;
	logic [BPM_W-1:0]    average_bpm_q8;
	logic [SAMPLE_W-1:0] ir_raw;
	modport source (output valid, current_bpm_q8, average_bpm_q8, ir_raw, input ready);
	modport sink   (input valid, current_bpm_q8, average_bpm_q8, ir_raw, output ready);
endinterface

// ===== sv/ppg_heart_rate_detector_core.sv =====
// PPG heart-rate detector. One sample beat (ir_sample, time_ms) gives one result beat.
// Smoothing window, baseline ring and rate history live in synchronous memories with
// one read and one write port, walked one word per cycle. A sample with no rate update
// passes the smoothing walk, the baseline write, the baseline walk, the peak step and
// the output step. A beat adds the restoring divider for the rate; when that rate
// lands in the 40..200 range the history walk and a short divider for the mean follow.
// After reset a clearing pass zeroes the memories before the first sample is taken.
// The result stays in an output register until taken; the next sample is accepted
// meanwhile, and its result waits in the last step, holding off input, while the
// output register is still full.
module ppg_heart_rate_detector_core #(
	parameter int SMOOTH_TAPS    = phrd_pkg::SMOOTH_TAPS_DEF,
	parameter int BASELINE_DEPTH = phrd_pkg::BASELINE_DEPTH_DEF,
	parameter int HISTORY_DEPTH  = phrd_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	phrd_in_if.sink                       in_ch,
	phrd_out_if.source                    out_ch,
	input  logic                          cfg_we,
	input  logic [phrd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [phrd_pkg::CFG_W-1:0]    cfg_wdata
);
	import phrd_pkg::*;

	localparam int SW = (SMOOTH_TAPS > 1) ? $clog2(SMOOTH_TAPS) : 1;
	localparam int BW = $clog2(BASELINE_DEPTH);
	localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CLR_N = (SMOOTH_TAPS > BASELINE_DEPTH)
		? ((SMOOTH_TAPS > HISTORY_DEPTH) ? SMOOTH_TAPS : HISTORY_DEPTH)
		: ((BASELINE_DEPTH > HISTORY_DEPTH) ? BASELINE_DEPTH : HISTORY_DEPTH);
	localparam int CW = $clog2(CLR_N + 1);
	localparam int SSUM_W = SAMPLE_W + $clog2(SMOOTH_TAPS + 1);
	localparam int BSUM_W = SAMPLE_W + $clog2(BASELINE_DEPTH + 1);
	localparam int HSUM_W = BPM_W + $clog2(HISTORY_DEPTH + 1);
	localparam int HCNT_W = $clog2(HISTORY_DEPTH + 1);

	// memories
	logic [SAMPLE_W-1:0] smem [SMOOTH_TAPS];
	logic [SAMPLE_W-1:0] bmem [BASELINE_DEPTH];
	logic [BPM_W-1:0]    hmem [HISTORY_DEPTH];

	phrd_state_t state_q, state_d;
	logic [CW-1:0]   cnt_q;
	logic [SW-1:0]   sslot_q;
	logic [BW-1:0]   bslot_q;
	logic [HW-1:0]   hslot_q;
	logic signed [AC_W-1:0] ac_prev_q, ac_pp_q, ac_q;
	logic            latch_q;
	logic [TIME_W-1:0] last_q;
	logic [BPM_W-1:0]  bpm_now_q, bpm_mean_q;
	logic signed [AC_W-1:0] thr_q;
	logic [GAP_W-1:0]  gap_q;
	logic [SAMPLE_W-1:0] samp_q;
	logic [TIME_W-1:0]   now_q;
	logic [SSUM_W-1:0]   ssum_q;
	logic [BSUM_W-1:0]   bsum_q;
	logic [HSUM_W-1:0]   hsum_q;
	logic [SAMPLE_W-1:0] smooth_q;
	logic                rd_v_q;
	logic                tail_q;
	logic [SAMPLE_W-1:0] srd_q, brd_q;
	logic [BPM_W-1:0]    hrd_q;
	logic [TIME_W-1:0]   rem_q, quo_q, dvsr_q;
	logic [5:0]          dstep_q;
	logic [HCNT_W-1:0]   hcnt_q;
	logic                out_v_q;
	logic [BPM_W-1:0]    o_cur_q, o_avg_q;
	logic [SAMPLE_W-1:0] o_raw_q;

	logic in_fire, last_cnt;
	logic signed [AC_W-1:0] ac_c;
	logic [TIME_W-1:0] interval;
	logic qualify, gap_ok, in_range;
	logic [TIME_W:0] dsub;
	logic [TIME_W-1:0] rem_sh;

	assign in_fire = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_v_q;
	assign out_ch.current_bpm_q8 = o_cur_q;
	assign out_ch.average_bpm_q8 = o_avg_q;
	assign out_ch.ir_raw = o_raw_q;

	assign ac_c = $signed({1'b0, smooth_q}) -
		$signed({1'b0, SAMPLE_W'(bsum_q / BASELINE_DEPTH)});
	assign interval = now_q - last_q;
	// current ac is ac_c at the peak step; ac_q and ac_prev_q are the two before it
	assign qualify = (ac_c > ac_q) && (ac_q > ac_prev_q) && (ac_c > thr_q) && !latch_q;
	assign gap_ok = interval > TIME_W'(gap_q);
	assign in_range = (bpm_now_q >= BPM_LOW) && (bpm_now_q <= BPM_HIGH);
	assign rem_sh = {rem_q[TIME_W-2:0], quo_q[TIME_W-1]};
	assign dsub = {1'b0, rem_sh} - {1'b0, dvsr_q};

	always_comb begin
		case (state_q)
			ST_CLEAR:   last_cnt = (cnt_q == CW'(CLR_N - 1));
			ST_SMOOTH:  last_cnt = (cnt_q == CW'(SMOOTH_TAPS - 1));
			ST_BASE_RD: last_cnt = (cnt_q == CW'(BASELINE_DEPTH - 1));
			ST_MEAN:    last_cnt = (cnt_q == CW'(HISTORY_DEPTH - 1));
			default:    last_cnt = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:   if (last_cnt) state_d = ST_IDLE;
			ST_IDLE:    if (in_fire) state_d = ST_SMOOTH;
			ST_SMOOTH:  if (tail_q) state_d = ST_BASE_WR;
			ST_BASE_WR: state_d = ST_BASE_RD;
			ST_BASE_RD: if (tail_q) state_d = ST_PEAK;
			ST_PEAK: begin
				if (qualify && gap_ok && last_q != '0) state_d = ST_DIV;
				else state_d = ST_OUT;
			end
			ST_DIV:     if (dstep_q == 6'd32) state_d = ST_HIST;
			ST_HIST: begin
				if (in_range) state_d = ST_MEAN;
				else state_d = ST_OUT;
			end
			ST_MEAN:    if (tail_q) state_d = ST_AVG;
			ST_AVG:     if (dstep_q == 6'(HSUM_W)) state_d = ST_OUT;
			ST_OUT:     if (!out_v_q || out_ch.ready) state_d = ST_IDLE;
			default:    state_d = ST_CLEAR;
		endcase
	end

	// memory ports; read address is the walk counter, read data lands next cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			if (cnt_q < CW'(SMOOTH_TAPS)) smem[cnt_q[SW-1:0]] <= '0;
			if (cnt_q < CW'(BASELINE_DEPTH)) bmem[cnt_q[BW-1:0]] <= '0;
			if (cnt_q < CW'(HISTORY_DEPTH)) hmem[cnt_q[HW-1:0]] <= '0;
		end else begin
			if (in_fire) smem[sslot_q] <= in_ch.ir_sample;
			if (state_q == ST_BASE_WR) bmem[bslot_q] <= smooth_q;
			if (state_q == ST_HIST && in_range) hmem[hslot_q] <= bpm_now_q;
		end
		srd_q <= smem[cnt_q[SW-1:0]];
		brd_q <= bmem[cnt_q[BW-1:0]];
		hrd_q <= hmem[cnt_q[HW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			rd_v_q <= 1'b0;
			tail_q <= 1'b0;
			sslot_q <= '0; bslot_q <= '0; hslot_q <= '0;
			ac_prev_q <= '0; ac_pp_q <= '0; ac_q <= '0;
			latch_q <= 1'b0; last_q <= '0;
			bpm_now_q <= '0; bpm_mean_q <= '0;
			thr_q <= '0; gap_q <= GAP_W'(300);
			out_v_q <= 1'b0;
			dstep_q <= '0;
			hcnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_THRESHOLD: thr_q <= $signed(cfg_wdata);
					REG_MIN_GAP:   gap_q <= cfg_wdata[GAP_W-1:0];
					default: ;
				endcase
			end
			if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			case (state_q)
				ST_CLEAR: cnt_q <= last_cnt ? '0 : cnt_q + 1'b1;
				ST_IDLE: begin
					cnt_q <= '0;
					rd_v_q <= 1'b0;
					tail_q <= 1'b0;
					ssum_q <= '0;
					bsum_q <= '0;
					if (in_fire) begin
						samp_q <= in_ch.ir_sample;
						now_q <= in_ch.time_ms;
						sslot_q <= (sslot_q == SW'(SMOOTH_TAPS - 1)) ? '0 : sslot_q + 1'b1;
					end
				end
				ST_SMOOTH: begin
					rd_v_q <= 1'b1;
					// tail marks that the last address was read the cycle before
					tail_q <= last_cnt;
					if (!last_cnt) cnt_q <= cnt_q + 1'b1;
					if (rd_v_q) ssum_q <= ssum_q + SSUM_W'(srd_q);
					if (tail_q) begin
						smooth_q <= SAMPLE_W'((ssum_q + SSUM_W'(srd_q)) / SMOOTH_TAPS);
						cnt_q <= '0;
					end
				end
				ST_BASE_WR: begin
					rd_v_q <= 1'b0;
					tail_q <= 1'b0;
					cnt_q <= '0;
					bslot_q <= (bslot_q == BW'(BASELINE_DEPTH - 1)) ? '0 : bslot_q + 1'b1;
				end
				ST_BASE_RD: begin
					rd_v_q <= 1'b1;
					tail_q <= last_cnt;
					if (!last_cnt) cnt_q <= cnt_q + 1'b1;
					if (rd_v_q) bsum_q <= bsum_q + BSUM_W'(brd_q);
				end
				ST_PEAK: begin
					// bsum_q holds the full ring sum here
					ac_q <= ac_c;
					ac_prev_q <= ac_q;
					ac_pp_q <= ac_prev_q;
					rem_q <= '0;
					quo_q <= 32'(BPM_NUMERATOR);
					dvsr_q <= interval;
					dstep_q <= '0;
				end
				ST_DIV: begin
					if (dstep_q == 6'd32) begin
						bpm_now_q <= (quo_q[TIME_W-1:BPM_W] != '0) ? '1 : quo_q[BPM_W-1:0];
					end else begin
						dstep_q <= dstep_q + 1'b1;
						if (!dsub[TIME_W]) begin
							rem_q <= dsub[TIME_W-1:0];
							quo_q <= {quo_q[TIME_W-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[TIME_W-2:0], 1'b0};
						end
					end
				end
				ST_HIST: begin
					cnt_q <= '0;
					rd_v_q <= 1'b0;
					tail_q <= 1'b0;
					hsum_q <= '0;
					if (in_range) begin
						if (hslot_q == HW'(HISTORY_DEPTH - 1)) begin
							hslot_q <= '0;
						end else begin
							hslot_q <= hslot_q + 1'b1;
						end
						if (hcnt_q != HCNT_W'(HISTORY_DEPTH)) hcnt_q <= hcnt_q + 1'b1;
					end
				end
				ST_MEAN: begin
					// unwritten entries read as zero, so sum all and divide by count
					rd_v_q <= 1'b1;
					tail_q <= last_cnt;
					if (!last_cnt) cnt_q <= cnt_q + 1'b1;
					if (rd_v_q) hsum_q <= hsum_q + HSUM_W'(hrd_q);
					if (tail_q) begin
						// left-align the sum so HSUM_W steps leave the quotient in the low bits
						rem_q <= '0;
						quo_q <= {hsum_q + HSUM_W'(hrd_q), {(TIME_W - HSUM_W){1'b0}}};
						dvsr_q <= TIME_W'(hcnt_q);
						dstep_q <= '0;
					end
				end
				ST_AVG: begin
					if (dstep_q == 6'(HSUM_W)) begin
						bpm_mean_q <= quo_q[BPM_W-1:0];
					end else begin
						dstep_q <= dstep_q + 1'b1;
						if (!dsub[TIME_W]) begin
							rem_q <= dsub[TIME_W-1:0];
							quo_q <= {quo_q[TIME_W-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[TIME_W-2:0], 1'b0};
						end
					end
				end
				ST_OUT: begin
					if (!out_v_q || out_ch.ready) begin
						out_v_q <= 1'b1;
						o_cur_q <= bpm_now_q;
						o_avg_q <= bpm_mean_q;
						o_raw_q <= samp_q;
					end
				end
				default: ;
			endcase
			// peak bookkeeping resolves at the peak step using the previous ac values
			if (state_q == ST_PEAK) begin
				if (qualify) begin
					if (gap_ok) begin
						last_q <= now_q;
						latch_q <= 1'b1;
					end
				end else if (ac_c < ac_q) begin
					latch_q <= 1'b0;
				end
			end
		end
	end
endmodule

// ===== sv/phrd_checker.sv =====
module phrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] average_bpm_q8,
	input logic [17:0] ir_raw
);
	// sample accepted only once the prior result has been produced
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(ir_raw))) else $error("result dropped");
	a_avg_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (average_bpm_q8 <= 16'd51200)) else $error("average out of range");
endmodule

bind ppg_heart_rate_detector_core phrd_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.average_bpm_q8(out_ch.average_bpm_q8), .ir_raw(out_ch.ir_raw)
);
